@@ hw/rtl/bfa_pkg.sv @@
// Shared types and codes for the best-fit block allocator.
// No dependencies; every other file of the block refers to this package.
package bfa_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam int unsigned SizeW = 32;
  localparam int unsigned SlotW = 3;

  // Input item.
  typedef struct packed {
    logic [1:0]       opcode;
    logic [SizeW-1:0] size_value;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [SizeW-1:0] granted_size;
    logic [SlotW-1:0] granted_slot;
  } out_t;

endpackage

@@ hw/rtl/bfa_size_mem.sv @@
// Block size store: one write port and one read port with registered read data.
// Depends on bfa_pkg for the size width.
module bfa_size_mem #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]  wr_addr_i,
  input  logic [bfa_pkg::SizeW-1:0]     wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]  rd_addr_i,
  output logic [bfa_pkg::SizeW-1:0]     rd_data_o
);

  logic [bfa_pkg::SizeW-1:0] mem_q [NUM_SLOTS];
  logic [bfa_pkg::SizeW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/bfa_ctrl.sv @@
// Sequencer of the allocator: slot valid bits, slot scans and result forming.
// Depends on bfa_pkg and drives the ports of bfa_size_mem.
module bfa_ctrl #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfa_pkg::in_t                  in_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bfa_pkg::out_t                 res_data_o,
  output logic                          mem_wr_en_o,
  output logic [$clog2(NUM_SLOTS)-1:0]  mem_wr_addr_o,
  output logic [bfa_pkg::SizeW-1:0]     mem_wr_data_o,
  output logic                          mem_rd_en_o,
  output logic [$clog2(NUM_SLOTS)-1:0]  mem_rd_addr_o,
  input  logic [bfa_pkg::SizeW-1:0]     mem_rd_data_i
);

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_REQ  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [1:0]                op_q, op_d;
  logic [bfa_pkg::SizeW-1:0] val_q, val_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      issue_q, issue_d;
  logic                      pend_q, pend_d;
  logic [IdxW-1:0]           pend_idx_q, pend_idx_d;
  logic                      pend_vld_q, pend_vld_d;
  logic                      found_q, found_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic [bfa_pkg::SizeW-1:0] best_size_q, best_size_d;
  bfa_pkg::out_t             res_q, res_d;
  logic [NUM_SLOTS-1:0]      valid_q, valid_d;

  logic                      hit;
  logic                      fin_found;
  logic [IdxW-1:0]           fin_idx;
  logic [bfa_pkg::SizeW-1:0] fin_size;

  // A slot read last cycle fits and beats the best so far; ties keep the lower slot.
  assign hit = pend_q && pend_vld_q && (mem_rd_data_i >= val_q) &&
               (!found_q || (mem_rd_data_i < best_size_q));
  assign fin_found = found_q || hit;
  assign fin_idx   = hit ? pend_idx_q : best_idx_q;
  assign fin_size  = hit ? mem_rd_data_i : best_size_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_RESP);
  assign res_data_o    = res_q;
  assign mem_rd_en_o   = (state_q == S_REQ) && issue_q;
  assign mem_rd_addr_o = idx_q;
  assign mem_wr_en_o   = (state_q == S_ADD) && !valid_q[idx_q];
  assign mem_wr_addr_o = idx_q;
  assign mem_wr_data_o = val_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pend_vld_d  = pend_vld_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    res_d       = res_q;
    valid_d     = valid_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = in_data_i.opcode;
          val_d       = in_data_i.size_value;
          idx_d       = '0;
          issue_d     = 1'b1;
          found_d     = 1'b0;
          best_idx_d  = '0;
          best_size_d = '0;
          res_d       = '{status: bfa_pkg::ST_NOFIT, granted_size: '0, granted_slot: '0};
          case (in_data_i.opcode)
            bfa_pkg::OP_ADD: state_d = S_ADD;
            bfa_pkg::OP_REQ: state_d = S_REQ;
            bfa_pkg::OP_CLEAR: begin
              valid_d      = '0;
              res_d.status = bfa_pkg::ST_CLEARED;
              state_d      = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      // Walk the valid bits to the lowest free slot; the size is written there.
      S_ADD: begin
        if (!valid_q[idx_q]) begin
          valid_d[idx_q] = 1'b1;
          best_idx_d     = idx_q;
          res_d          = '{status: bfa_pkg::ST_OK, granted_size: '0,
                             granted_slot: bfa_pkg::SlotW'(idx_q)};
          state_d        = S_RESP;
        end else if (idx_q == LastIdx) begin
          res_d   = '{status: bfa_pkg::ST_FULL, granted_size: '0, granted_slot: '0};
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Issue one read per cycle and compare the data returned in the cycle after its read.
      S_REQ: begin
        if (issue_q) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          pend_vld_d = valid_q[idx_q];
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (hit) begin
          found_d     = 1'b1;
          best_idx_d  = pend_idx_q;
          best_size_d = mem_rd_data_i;
        end
        if (pend_q && (pend_idx_q == LastIdx)) begin
          pend_d = 1'b0;
          if (fin_found) begin
            valid_d[fin_idx] = 1'b0;
            res_d = '{status: bfa_pkg::ST_OK, granted_size: fin_size,
                      granted_slot: bfa_pkg::SlotW'(fin_idx)};
          end else begin
            res_d = '{status: bfa_pkg::ST_NOFIT, granted_size: '0, granted_slot: '0};
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      valid_q <= valid_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    pend_idx_q  <= pend_idx_d;
    pend_vld_q  <= pend_vld_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    res_q       <= res_d;
  end

  // A granted block is no longer listed as free while its result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (op_q == bfa_pkg::OP_REQ) && (res_q.status == bfa_pkg::ST_OK))
      |-> !valid_q[best_idx_q])
    else $error("granted slot still marked free");

  // An added block is listed as free while its result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (op_q == bfa_pkg::OP_ADD) && (res_q.status == bfa_pkg::ST_OK))
      |-> valid_q[best_idx_q])
    else $error("added slot not marked valid");

  // A granted block always covers the requested size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (op_q == bfa_pkg::OP_REQ) && (res_q.status == bfa_pkg::ST_OK))
      |-> (res_q.granted_size >= val_q))
    else $error("granted block smaller than request");

  // No read is outstanding when a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!pend_q && !mem_rd_en_o))
    else $error("scan read outstanding while idle");

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_q)))
    else $error("result dropped before transfer");

endmodule

@@ hw/rtl/best_fit_block_allocator.sv @@
// Top level of the best-fit block allocator: sequencer, size store, output register.
// Depends on bfa_pkg, bfa_size_mem and bfa_ctrl.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (bfa_pkg::in_t)
//   out       output     out_valid_o / out_ready_i  out_data_o (bfa_pkg::out_t)
//
// One item is worked on at a time. An add walks the valid bits one slot per cycle
// up to the lowest free slot. A request reads every slot of the size store through
// its single read port. Clear and the unused opcode go straight to the result. A
// result waits in the output register, so the next item is taken while it is
// stalled. Reset invalidates every slot at once.
module best_fit_block_allocator #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bfa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bfa_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);

  logic                      res_valid;
  logic                      res_ready;
  bfa_pkg::out_t             res_data;
  logic                      mem_wr_en;
  logic [IdxW-1:0]           mem_wr_addr;
  logic [bfa_pkg::SizeW-1:0] mem_wr_data;
  logic                      mem_rd_en;
  logic [IdxW-1:0]           mem_rd_addr;
  logic [bfa_pkg::SizeW-1:0] mem_rd_data;

  logic                      out_valid_q, out_valid_d;
  bfa_pkg::out_t             out_data_q, out_data_d;

  bfa_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_o    (res_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  bfa_size_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_size_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Output register: takes a new result when empty or when draining this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = res_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ dv/tb_best_fit_block_allocator.sv @@
// Self-checking testbench for best_fit_block_allocator: directed table, then random traffic.
// Depends on bfa_pkg and the allocator RTL; holds its own free-block table to predict grants.
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;

  localparam int unsigned NumSlots     = 8;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned RandomItems  = 750;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 4 * (NumSlots + 2);
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned MaxReports   = 10;
  localparam logic [1:0]  OpUnused     = 2'd3;

  // One row of the directed table; want is only used when typed is set.
  typedef struct {
    bfa_pkg::in_t  item;
    bit            typed;
    bfa_pkg::out_t want;
  } dir_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  bfa_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  bfa_pkg::out_t out_data_o;

  // Shadow free-block table.
  logic [bfa_pkg::SizeW-1:0] free_size [NumSlots];
  bit                        free_valid[NumSlots];

  bfa_pkg::out_t grants_due[$];
  dir_row_t      directed_rows[$];
  int unsigned   mismatch_count  = 0;
  int unsigned   items_taken     = 0;
  bit            long_hold_done  = 1'b0;

  best_fit_block_allocator #(
    .NUM_SLOTS(NumSlots)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Applies one item to the shadow table and returns the grant it should produce.
  function automatic bfa_pkg::out_t predict_grant(input bfa_pkg::in_t item);
    bfa_pkg::out_t res;
    bit            found;
    int unsigned   best;
    res   = '0;
    found = 1'b0;
    best  = 0;
    case (item.opcode)
      bfa_pkg::OP_ADD: begin
        for (int unsigned k = 0; k < NumSlots; k++) begin
          if (!found && !free_valid[k]) begin
            found         = 1'b1;
            free_size[k]  = item.size_value;
            free_valid[k] = 1'b1;
            res.granted_slot = bfa_pkg::SlotW'(k);
          end
        end
        res.status = found ? bfa_pkg::ST_OK : bfa_pkg::ST_FULL;
      end
      bfa_pkg::OP_REQ: begin
        for (int unsigned k = 0; k < NumSlots; k++) begin
          if (free_valid[k] && free_size[k] >= item.size_value) begin
            if (!found || free_size[k] < free_size[best]) begin
              best  = k;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          free_valid[best] = 1'b0;
          res.status       = bfa_pkg::ST_OK;
          res.granted_size = free_size[best];
          res.granted_slot = bfa_pkg::SlotW'(best);
        end else begin
          res.status = bfa_pkg::ST_NOFIT;
        end
      end
      bfa_pkg::OP_CLEAR: begin
        for (int unsigned k = 0; k < NumSlots; k++) begin
          free_valid[k] = 1'b0;
        end
        res.status = bfa_pkg::ST_CLEARED;
      end
      default: begin
        res.status = bfa_pkg::ST_NOFIT;
      end
    endcase
    return res;
  endfunction

  function automatic void stage_row(input logic [1:0] op,
                                    input logic [bfa_pkg::SizeW-1:0] size,
                                    input bit typed, input logic [1:0] st,
                                    input logic [bfa_pkg::SizeW-1:0] gsize,
                                    input logic [bfa_pkg::SlotW-1:0] gslot);
    dir_row_t row;
    row.item.opcode        = op;
    row.item.size_value    = size;
    row.typed              = typed;
    row.want.status        = st;
    row.want.granted_size  = gsize;
    row.want.granted_slot  = gslot;
    directed_rows.push_back(row);
  endfunction

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sizes lean on small values so that ties and exact fits are common.
  function automatic logic [bfa_pkg::SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 31);
    if (r < 60) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    if (r < 70) return 32'h8000_0000 + $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  // Requests usually aim at a block that is held now: exact, a bit under, or one above.
  function automatic logic [bfa_pkg::SizeW-1:0] pick_request_size();
    int unsigned               held[$];
    logic [bfa_pkg::SizeW-1:0] s;
    logic [bfa_pkg::SizeW-1:0] d;
    for (int unsigned k = 0; k < NumSlots; k++) begin
      if (free_valid[k]) held.push_back(k);
    end
    if (held.size() == 0 || $urandom_range(0, 9) < 4) return pick_size();
    s = free_size[held[$urandom_range(0, held.size() - 1)]];
    case ($urandom_range(0, 2))
      0: return s;
      1: begin
        d = $urandom_range(1, 3);
        return (s < d) ? '0 : s - d;
      end
      default: return s + 1;
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input bfa_pkg::out_t want,
                                        input bfa_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: want status %0d size %h slot %0d, got status %0d size %h slot %0d",
               $realtime, what, want.status, want.granted_size, want.granted_slot,
               got.status, got.granted_size, got.granted_slot);
    end
  endfunction

  // Offers one item, waits for its transfer and records the grant it should bring.
  task automatic offer(input bfa_pkg::in_t item, input bit typed, input bfa_pkg::out_t want);
    bfa_pkg::out_t model;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model = predict_grant(item);
    grants_due.push_back(typed ? want : model);
    items_taken++;
  endtask

  initial begin : stimulus
    bfa_pkg::in_t item;
    int unsigned  r;
    int unsigned  gap;
    bit           calm;
    for (int unsigned k = 0; k < NumSlots; k++) begin
      free_size[k]  = '0;
      free_valid[k] = 1'b0;
    end

    // Empty table, clear, unused opcode, fill to full with a tie, then drain.
    stage_row(bfa_pkg::OP_REQ,   32'd0,         1'b1, bfa_pkg::ST_NOFIT,   '0, '0);
    stage_row(bfa_pkg::OP_CLEAR, 32'd0,         1'b1, bfa_pkg::ST_CLEARED, '0, '0);
    stage_row(OpUnused,          32'hFFFF_FFFF, 1'b1, bfa_pkg::ST_NOFIT,   '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd0,         1'b1, bfa_pkg::ST_OK,      '0, 3'd0);
    stage_row(bfa_pkg::OP_ADD,   32'hFFFF_FFFF, 1'b1, bfa_pkg::ST_OK,      '0, 3'd1);
    stage_row(bfa_pkg::OP_ADD,   32'd100,       1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd50,        1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd100,       1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd7,         1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'h8000_0000, 1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd1,         1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd5,         1'b1, bfa_pkg::ST_FULL,    '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'd60,        1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'd60,        1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'd0,         1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'hFFFF_FFFF, 1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'hFFFF_FFFF, 1'b1, bfa_pkg::ST_NOFIT,   '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'd5,         1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'h7FFF_FFFF, 1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(OpUnused,          32'd0,         1'b1, bfa_pkg::ST_NOFIT,   '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'd50,        1'b0, bfa_pkg::ST_OK,      '0, '0);
    stage_row(bfa_pkg::OP_CLEAR, 32'h5555_5555, 1'b1, bfa_pkg::ST_CLEARED, '0, '0);
    stage_row(bfa_pkg::OP_REQ,   32'd0,         1'b1, bfa_pkg::ST_NOFIT,   '0, '0);
    stage_row(bfa_pkg::OP_ADD,   32'hAAAA_AAAA, 1'b1, bfa_pkg::ST_OK,      '0, 3'd0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with random gaps between rows.
    foreach (directed_rows[n]) begin
      offer(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    // Random part; two stretches run without any sender gaps.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        item.opcode     = bfa_pkg::OP_ADD;
        item.size_value = pick_size();
      end else if (r < 93) begin
        item.opcode     = bfa_pkg::OP_REQ;
        item.size_value = pick_request_size();
      end else if (r < 97) begin
        item.opcode     = bfa_pkg::OP_CLEAR;
        item.size_value = $urandom;
      end else begin
        item.opcode     = OpUnused;
        item.size_value = $urandom;
      end
      offer(item, 1'b0, '0);
      calm = (n >= 200 && n < 260) || (n >= 500 && n < 560);
      gap  = calm ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Let every grant come back, then watch a while for stray results.
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("best_fit_block_allocator regression: pass");
    end else begin
      $display("best_fit_block_allocator regression: fail");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off that backs up the block.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && items_taken >= 120) begin
        long_hold_done = 1'b1;
        stall_left     = HoldCycles;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left != 0) begin
          calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          calm_left = 60;
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Compare each result transfer with the oldest pending grant.
  bfa_pkg::out_t seen_grant;
  bfa_pkg::out_t due_grant;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_grant = out_data_o;
      if (grants_due.size() == 0) begin
        note_mismatch("result with nothing pending", '0, seen_grant);
      end else begin
        due_grant = grants_due.pop_front();
        if (seen_grant.status !== due_grant.status ||
            seen_grant.granted_size !== due_grant.granted_size ||
            seen_grant.granted_slot !== due_grant.granted_slot) begin
          note_mismatch("result differs", due_grant, seen_grant);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("best_fit_block_allocator regression: fail");
    $finish;
  end

endmodule
